FILE: sv/matrix_multiply_add_assert.svh
// ----------------------------------------------------------------------------
// Matrix multiply-add assertion macros
// Clocked assertion helpers used by the RTL controller of the block.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ADD_ASSERT_SVH
`define MATRIX_MULTIPLY_ADD_ASSERT_SVH

`ifndef ASSERT_OFF

`define MMA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define MMA_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define MMA_ASSERT(label, prop, msg)

`define MMA_ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: sv/mma_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply-add package
// Shared widths, codes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mma_pkg;

	localparam int MAX_DIM_DEFAULT = 8;
	localparam int DATA_W          = 16;
	localparam int FRAC_W          = 8;
	localparam int IDX_PORT_W      = 3;
	localparam int CFG_W           = 4;
	localparam int CFG_IDX_W       = 2;
	// 8 products of 32 bits plus the addend at product scale
	localparam int ACC_W           = 36;

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_LOAD_D = 2'd2,
		OP_START  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT   = 2'd0,
		REG_INNER_COUNT = 2'd1,
		REG_COL_COUNT   = 2'd2,
		REG_ADD_ENABLE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                  load_in;
		logic                  mac_issue;
		logic                  mac_first;
		logic                  load_out;
		logic                  out_last;
		logic                  add_en;
		logic [IDX_PORT_W-1:0] row;
		logic [IDX_PORT_W-1:0] col;
		logic [IDX_PORT_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

FILE: sv/mma_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/mma_ctrl.sv
// ----------------------------------------------------------------------------
// Matrix multiply-add controller
// Holds configuration, walks rows, columns and the inner index, and
// sequences multiply-accumulate, drain and result hand-off.
// ----------------------------------------------------------------------------
`include "matrix_multiply_add_assert.svh"

module mma_ctrl import mma_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  status_t              status,
	output cmd_t                 cmd
);

	localparam int IDX_W = $clog2(MAX_DIM);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] row_count_q;
	logic [CFG_W-1:0] inner_count_q;
	logic [CFG_W-1:0] col_count_q;
	logic             add_enable_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] r_lim;
	logic [IDX_W-1:0] k_lim;
	logic [IDX_W-1:0] c_lim;
	logic             elem_last;
	logic             out_load;

	function automatic logic [IDX_W-1:0] last_idx(input logic [CFG_W-1:0] n);
		if (n == '0) return '0;
		if (int'(n) > MAX_DIM) return IDX_W'(MAX_DIM - 1);
		return IDX_W'(n - 1'b1);
	endfunction

	assign r_lim     = last_idx(row_count_q);
	assign k_lim     = last_idx(inner_count_q);
	assign c_lim     = last_idx(col_count_q);
	assign elem_last = (i_q == r_lim) && (j_q == c_lim);
	assign out_load  = (state_q == ST_DRAIN) && !status.pipe_busy && status.out_free;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load_in   = in_valid && !in_stall && (op != OP_START);
		cmd.mac_issue = (state_q == ST_MAC);
		cmd.mac_first = (state_q == ST_MAC) && (k_q == '0);
		cmd.load_out  = out_load;
		cmd.out_last  = elem_last;
		cmd.add_en    = add_enable_q;
		cmd.row       = IDX_PORT_W'(i_q);
		cmd.col       = IDX_PORT_W'(j_q);
		cmd.k         = IDX_PORT_W'(k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= CFG_W'(1);
			inner_count_q <= CFG_W'(1);
			col_count_q   <= CFG_W'(1);
			add_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROW_COUNT:   row_count_q   <= cfg_data;
				REG_INNER_COUNT: inner_count_q <= cfg_data;
				REG_COL_COUNT:   col_count_q   <= cfg_data;
				REG_ADD_ENABLE:  add_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && (op == OP_START)) begin
						state_q <= ST_MAC;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_MAC: begin
					if (k_q == k_lim) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MAC;
							if (j_q == c_lim) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MMA_ASSERT(a_load_out_free, cmd.load_out |-> status.out_free, "result loaded while output full")
	`MMA_ASSERT(a_issue_busy, cmd.mac_issue |=> status.pipe_busy, "issued MAC not in pipeline")
	`MMA_ASSERT(a_last_idle, (cmd.load_out && cmd.out_last) |=> (state_q == ST_IDLE), "no idle after last")
	`MMA_ASSERT_NEVER(a_load_busy, cmd.load_in && (state_q != ST_IDLE), "load accepted while busy")

endmodule

FILE: sv/mma_datapath.sv
// ----------------------------------------------------------------------------
// Matrix multiply-add datapath
// Element stores, shared multiplier with accumulator, addend, floor shift,
// saturation and the output register.
// ----------------------------------------------------------------------------
module mma_datapath import mma_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output status_t                      status,
	input  logic [1:0]                   op,
	input  logic [IDX_PORT_W-1:0]        row_index,
	input  logic [IDX_PORT_W-1:0]        col_index,
	input  logic signed [DATA_W-1:0]     elem_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [IDX_PORT_W-1:0]        out_row,
	output logic [IDX_PORT_W-1:0]        out_col,
	output logic signed [DATA_W-1:0]     out_value,
	output logic                         last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SH_W   = ACC_W - FRAC_W;
	localparam logic signed [SH_W-1:0] SAT_MAX = SH_W'(2 ** (DATA_W - 1) - 1);
	localparam logic signed [SH_W-1:0] SAT_MIN = SH_W'(-(2 ** (DATA_W - 1)));

	logic                     in_range;
	logic                     a_we;
	logic                     b_we;
	logic                     d_we;
	logic [ADDR_W-1:0]        waddr;
	logic [ADDR_W-1:0]        a_raddr;
	logic [ADDR_W-1:0]        b_raddr;
	logic [ADDR_W-1:0]        d_raddr;
	logic [DATA_W-1:0]        a_rd;
	logic [DATA_W-1:0]        b_rd;
	logic [DATA_W-1:0]        d_rd;
	logic                     mac_s1;
	logic                     first_s1;
	logic                     mac_s2;
	logic                     first_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  total;
	logic signed [SH_W-1:0]   shifted;
	logic signed [DATA_W-1:0] sat;
	logic                     out_valid_q;

	function automatic logic [ADDR_W-1:0] addr(input logic [IDX_PORT_W-1:0] r,
		input logic [IDX_PORT_W-1:0] c);
		return ADDR_W'(int'(r) * MAX_DIM + int'(c));
	endfunction

	assign in_range = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign waddr    = addr(row_index, col_index);
	assign a_raddr  = addr(cmd.row, cmd.k);
	assign b_raddr  = addr(cmd.k, cmd.col);
	assign d_raddr  = addr(cmd.row, cmd.col);

	always_comb begin
		a_we = 1'b0;
		b_we = 1'b0;
		d_we = 1'b0;
		if (cmd.load_in && in_range) begin
			case (op_t'(op))
				OP_LOAD_A: a_we = 1'b1;
				OP_LOAD_B: b_we = 1'b1;
				OP_LOAD_D: d_we = 1'b1;
				default: ;
			endcase
		end
	end

	mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (a_raddr),
		.rdata (a_rd)
	);

	mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (b_raddr),
		.rdata (b_rd)
	);

	mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_d_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (d_raddr),
		.rdata (d_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= 1'b0;
			mac_s2 <= 1'b0;
		end else begin
			mac_s1 <= cmd.mac_issue;
			mac_s2 <= mac_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.mac_first;
		first_s2 <= first_s1;
		prod_s2  <= $signed(a_rd) * $signed(b_rd);
		if (mac_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign addend  = cmd.add_en ? (ACC_W'($signed(d_rd)) <<< FRAC_W) : '0;
	assign total   = acc_q + addend;
	assign shifted = SH_W'(total >>> FRAC_W);

	always_comb begin
		if (shifted > SAT_MAX) begin
			sat = DATA_W'(SAT_MAX);
		end else if (shifted < SAT_MIN) begin
			sat = DATA_W'(SAT_MIN);
		end else begin
			sat = DATA_W'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_row   <= cmd.row;
			out_col   <= cmd.col;
			out_value <= sat;
			last      <= cmd.out_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign status.pipe_busy = mac_s1 || mac_s2;
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

FILE: sv/matrix_multiply_add.sv
// ----------------------------------------------------------------------------
// Matrix multiply-add
// R = A * B (+ D) in signed Q8.8, floor-shifted and saturated to 16 bits.
// ----------------------------------------------------------------------------
// Load beats (op 0, 1, 2) write one element of A, B or D each; a start
// beat streams R in row-major order with last on the final element. One
// shared multiplier does one multiply-accumulate per cycle while an element
// is computed: inner_count reads (1 to MAX_DIM), then a read, multiply and
// accumulate drain before the element is loaded into the output register.
// Input is stalled from the start beat until the final element sits in the
// output register; a stalled output register holds the next element back.
// Configuration must be written only while idle; the block itself does not
// enforce it.
module matrix_multiply_add import mma_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic [IDX_PORT_W-1:0]    row_index,
	input  logic [IDX_PORT_W-1:0]    col_index,
	input  logic signed [DATA_W-1:0] elem_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [IDX_PORT_W-1:0]    out_row,
	output logic [IDX_PORT_W-1:0]    out_col,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     last
);

	cmd_t    cmd;
	status_t status;

	mma_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.status    (status),
		.cmd       (cmd)
	);

	mma_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.row_index  (row_index),
		.col_index  (col_index),
		.elem_value (elem_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_value  (out_value),
		.last       (last)
	);

endmodule
